@@ src/skt_pkg.sv @@
// Shared types and codes for the sorted key table.
// Used by skt_cell, skt_chain and sorted_key_table_core; depends on nothing.
package skt_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [1:0] ACT_SEARCH = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic        [1:0]  action;
		logic signed [31:0] key;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] position;
		logic [6:0] count;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

@@ src/skt_cell.sv @@
// One table slot: holds an entry, compares it with the broadcast key and
// shifts toward a neighbor on insert or delete. Depends on skt_pkg.
module skt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  logic signed [31:0]  key,
	input  logic                occupied,
	input  skt_pkg::entry_t     ins_entry,
	input  skt_pkg::entry_t     left_entry,
	input  skt_pkg::entry_t     right_entry,
	input  logic                left_less,
	output skt_pkg::entry_t     entry,
	output logic                less,
	output logic                eq
);

	skt_pkg::entry_t entry_q;
	logic            less_q;
	logic            eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !less_q) begin
			entry_q <= left_less ? ins_entry : left_entry;
		end else if (ctrl.del && !less_q) begin
			entry_q <= right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_q <= 1'b0;
			eq_q   <= 1'b0;
		end else if (ctrl.cmp) begin
			less_q <= occupied && ($signed(entry_q.key) < $signed(key));
			eq_q   <= occupied && (entry_q.key == key);
		end
	end

	assign entry = entry_q;
	assign less  = less_q;
	assign eq    = eq_q;

endmodule

@@ src/skt_chain.sv @@
// Row of table slots, each wired to its left and right neighbor.
// Depends on skt_pkg and skt_cell.
module skt_chain #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  logic signed [31:0]  key,
	input  skt_pkg::entry_t     ins_entry,
	input  logic [CW-1:0]       count,
	output logic [CAPACITY-1:0] less_vec,
	output logic [CAPACITY-1:0] eq_vec
);

	skt_pkg::entry_t entries [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		skt_pkg::entry_t left_e;
		skt_pkg::entry_t right_e;
		logic            left_l;

		if (i == 0) begin : g_first
			assign left_e = ins_entry;
			assign left_l = 1'b1;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_l = less_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = entries[i];
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		skt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.key         (key),
			.occupied    (count > IDX),
			.ins_entry   (ins_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_less   (left_l),
			.entry       (entries[i]),
			.less        (less_vec[i]),
			.eq          (eq_vec[i])
		);
	end

endmodule

@@ src/sorted_key_table_core.sv @@
// Sorted key table: one slot cell per entry, sequenced by a small controller.
// Depends on skt_pkg and skt_chain.
//
// A request is taken when start is high and busy is low. In the compare
// state that follows, every cell compares its key with the request key in
// parallel; the controller then binary-searches the cells' less-than flags,
// one halving step per cycle (at most clog2(CAPACITY)+1 steps, then a
// decision), and in the apply state the cells at and above the found
// position shift at once for an insert or delete. done is high for a single
// cycle in the apply state; rsp holds the result from then until the next
// result is registered. The result cannot be held off: the receiver must
// take it in that cycle. busy falls with done, so the next request can be
// taken the cycle after the result. Slot contents are not cleared at reset;
// the entry count and the cells' compare flags are.
module sorted_key_table_core #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  skt_pkg::req_t req,
	output logic          done,
	output skt_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CMP   = 2'd1;
	localparam logic [1:0] S_SRCH  = 2'd2;
	localparam logic [1:0] S_APPLY = 2'd3;

	logic [1:0]          state_q;
	skt_pkg::req_t       req_q;
	skt_pkg::rsp_t       rsp_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic                ins_q;
	logic                del_q;
	logic [CAPACITY-1:0] less_vec;
	logic [CAPACITY-1:0] eq_vec;
	skt_pkg::cell_ctrl_t ctrl;
	skt_pkg::entry_t     ins_entry;
	logic [CW:0]         mid_sum;
	logic [CW-1:0]       mid;
	logic                hit;
	logic                full;
	logic [1:0]          status_d;
	logic [CW-1:0]       count_d;
	logic                ins_d;
	logic                del_d;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign hit     = (lo_q < count_q) && eq_vec[lo_q[IW-1:0]];
	assign full    = (count_q >= CW'(CAPACITY));

	always_comb begin
		status_d = hit ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
		count_d  = count_q;
		ins_d    = 1'b0;
		del_d    = 1'b0;
		unique case (req_q.action)
			skt_pkg::ACT_INSERT: begin
				if (hit) begin
					status_d = skt_pkg::ST_DUPLICATE;
				end else if (full) begin
					status_d = skt_pkg::ST_FULL;
				end else begin
					status_d = skt_pkg::ST_OK;
					count_d  = count_q + 1'b1;
					ins_d    = 1'b1;
				end
			end
			skt_pkg::ACT_DELETE: begin
				if (hit) begin
					count_d = count_q - 1'b1;
					del_d   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			ins_q   <= 1'b0;
			del_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					lo_q    <= '0;
					hi_q    <= count_q;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						if (less_vec[mid[IW-1:0]]) begin
							lo_q <= mid + 1'b1;
						end else begin
							hi_q <= mid;
						end
					end else begin
						count_q <= count_d;
						ins_q   <= ins_d;
						del_q   <= del_d;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					ins_q   <= 1'b0;
					del_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		if (state_q == S_SRCH && !(lo_q < hi_q)) begin
			rsp_q.status   <= status_d;
			rsp_q.position <= 7'(lo_q);
			rsp_q.count    <= 7'(count_d);
		end
	end

	assign ins_entry = '{key: req_q.key, value_a: req_q.value_a, value_b: req_q.value_b};

	assign ctrl.cmp = (state_q == S_CMP);
	assign ctrl.ins = (state_q == S_APPLY) && ins_q;
	assign ctrl.del = (state_q == S_APPLY) && del_q;

	skt_chain #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.key       (req_q.key),
		.ins_entry (ins_entry),
		.count     (count_q),
		.less_vec  (less_vec),
		.eq_vec    (eq_vec)
	);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_APPLY);
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (lo_q <= hi_q) && (hi_q <= count_q))
		else $error("search bounds out of order");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ins_q) |-> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("insert did not grow the table by one");

	a_req_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(req_q))
		else $error("request register changed during a transfer");
`endif

endmodule
